// ===== hdl/lbc_pkg.sv =====
package lbc_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned CH_N      = 3;
  localparam int unsigned PIX_W     = CH_W * CH_N;
  localparam int unsigned OPA_W     = 7;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned SETTING_W = OPA_W + MODE_W + 1;
  // a*(100-o) + m*o stays at or below 25500
  localparam int unsigned PROD_W    = 15;
  localparam int unsigned DIV_MUL_W = 13;
  localparam int unsigned DIV_P_W   = PROD_W + DIV_MUL_W;

  localparam logic [OPA_W-1:0] OPA_FULL = 7'd100;

  // floor(x/100) == (x*5243) >> 19 for every x below 43690
  localparam logic [DIV_MUL_W-1:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned          DIV100_SHIFT = 19;

  localparam logic [MODE_W-1:0] MODE_NORMAL     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DARKEN     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LIGHTEN    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIFFERENCE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NEGATE     = 3'd4;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic              enable;
    logic [MODE_W-1:0] mode;
    logic [OPA_W-1:0]  opacity;
  } setting_t;

  localparam setting_t SETTING_RESET = 11'd100;

  function automatic logic [OPA_W-1:0] clamp_opacity(input logic [OPA_W-1:0] o);
    return (o > OPA_FULL) ? OPA_FULL : o;
  endfunction

  // weighted sum for normal and darken
  function automatic prod_t mix_product(input chan_t a, input chan_t c,
                                        input logic [MODE_W-1:0] mode,
                                        input logic [OPA_W-1:0] o);
    chan_t m;
    prod_t pa;
    prod_t pm;
    m  = ((mode == MODE_DARKEN) && (a < c)) ? a : c;
    pa = PROD_W'(a) * PROD_W'(OPA_FULL - o);
    pm = PROD_W'(m) * PROD_W'(o);
    return pa + pm;
  endfunction

  function automatic prod_t scale_product(input chan_t c, input logic [OPA_W-1:0] o);
    return PROD_W'(c) * PROD_W'(o);
  endfunction

  function automatic chan_t div100(input prod_t x);
    logic [DIV_P_W-1:0] p;
    p = DIV_P_W'(x) * DIV_P_W'(DIV100_MUL);
    return p[DIV100_SHIFT +: CH_W];
  endfunction

  function automatic chan_t apply_mode(input chan_t a, input setting_t set,
                                       input prod_t prod_n, input prod_t prod_s);
    chan_t qn;
    chan_t qs;
    chan_t r;
    qn = div100(prod_n);
    qs = div100(prod_s);
    unique case (set.mode)
      MODE_NORMAL,
      MODE_DARKEN:     r = qn;
      MODE_LIGHTEN:    r = (a > qs) ? a : qs;
      MODE_DIFFERENCE: r = (a > qs) ? (a - qs) : (qs - a);
      MODE_NEGATE:     r = a ^ qs;
      default:         r = a;
    endcase
    return set.enable ? r : a;
  endfunction

endpackage

// ===== hdl/lbc_layer_stage.sv =====
module lbc_layer_stage #(
  parameter int unsigned LAYER_COUNT = 5,
  parameter int unsigned LAYER_IDX   = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  lbc_pkg::setting_t                      setting_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  lbc_pkg::pix_t                          in_pix_i,
  input  lbc_pkg::pix_t [LAYER_COUNT-1:0]        in_layers_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output lbc_pkg::pix_t                          out_pix_o,
  output lbc_pkg::pix_t [LAYER_COUNT-1:0]        out_layers_o
);
  import lbc_pkg::*;

  // first register: per-channel products
  logic                         a_valid_q;
  setting_t                     a_set_q;
  pix_t                         a_pix_q;
  pix_t     [LAYER_COUNT-1:0]   a_layers_q;
  prod_t    [CH_N-1:0]          a_prod_n_q, a_prod_n_d;
  prod_t    [CH_N-1:0]          a_prod_s_q, a_prod_s_d;
  logic     [OPA_W-1:0]         opa;

  // second register: divided and blended pixel
  logic                         b_valid_q;
  pix_t                         b_pix_q, b_pix_d;
  pix_t     [LAYER_COUNT-1:0]   b_layers_q;

  logic a_ready;
  logic b_ready;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  assign opa = clamp_opacity(setting_i.opacity);

  always_comb begin
    for (int ch = 0; ch < CH_N; ch++) begin
      a_prod_n_d[ch] = mix_product(in_pix_i[ch*CH_W +: CH_W],
                                   in_layers_i[LAYER_IDX][ch*CH_W +: CH_W],
                                   setting_i.mode, opa);
      a_prod_s_d[ch] = scale_product(in_layers_i[LAYER_IDX][ch*CH_W +: CH_W], opa);
    end
  end

  always_comb begin
    for (int ch = 0; ch < CH_N; ch++) begin
      b_pix_d[ch*CH_W +: CH_W] = apply_mode(a_pix_q[ch*CH_W +: CH_W], a_set_q,
                                            a_prod_n_q[ch], a_prod_s_q[ch]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) begin
      a_set_q    <= setting_i;
      a_pix_q    <= in_pix_i;
      a_layers_q <= in_layers_i;
      a_prod_n_q <= a_prod_n_d;
      a_prod_s_q <= a_prod_s_d;
    end
    if (a_valid_q && b_ready) begin
      b_pix_q    <= b_pix_d;
      b_layers_q <= a_layers_q;
    end
  end

  assign out_valid_o  = b_valid_q;
  assign out_pix_o    = b_pix_q;
  assign out_layers_o = b_layers_q;

endmodule

// ===== hdl/layer_blend_compositor.sv =====
// Layer blend compositor: each item on the slave stream carries a base pixel and the
// same pixel of LAYER_COUNT layers (three 8-bit channels each); the master stream
// returns one composited pixel per item. Layers apply from the highest index down
// to layer 0, each under its setting register (opacity percent, mode, enable) on the
// plain write port. Every layer owns two register stages, products and then the
// reciprocal divide by 100 with mode select; one item is accepted every cycle while
// the output takes items. Each stage holds its item while the next one is full, so
// a stall on the output fills bubbles first. Write settings only while no item is
// in flight.
module layer_blend_compositor #(
  parameter int unsigned LAYER_COUNT = 5
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [((LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1)-1:0] cfg_idx_i,
  input  logic [lbc_pkg::SETTING_W-1:0]             cfg_wdata_i,
  input  logic                                      s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // base_pixel, layer0_pixel, ..., layer(LAYER_COUNT-1)_pixel
  input  logic [(LAYER_COUNT+1)*lbc_pkg::PIX_W-1:0] s_axis_tdata_i,
  output logic                                      m_axis_tvalid_o,
  input  logic                                      m_axis_tready_i,
  // blended_pixel
  output logic [lbc_pkg::PIX_W-1:0]                 m_axis_tdata_o
);
  import lbc_pkg::*;

  localparam int unsigned IDX_W = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;

  setting_t [LAYER_COUNT-1:0] settings_q;

  logic                       link_valid [LAYER_COUNT+1];
  logic                       link_ready [LAYER_COUNT+1];
  pix_t                       link_pix   [LAYER_COUNT+1];
  pix_t [LAYER_COUNT-1:0]     link_layers[LAYER_COUNT+1];

  // drop writes beyond the register list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAYER_COUNT; k++) begin
        settings_q[k] <= SETTING_RESET;
      end
    end else begin
      for (int k = 0; k < LAYER_COUNT; k++) begin
        if (cfg_we_i && (cfg_idx_i == IDX_W'(k))) begin
          settings_q[k] <= setting_t'(cfg_wdata_i);
        end
      end
    end
  end

  assign link_valid[0]  = s_axis_tvalid_i;
  assign s_axis_tready_o = link_ready[0];
  assign link_pix[0]    = s_axis_tdata_i[PIX_W-1:0];
  assign link_layers[0] = s_axis_tdata_i[PIX_W +: LAYER_COUNT*PIX_W];

  for (genvar s = 0; s < LAYER_COUNT; s++) begin : g_stage
    lbc_layer_stage #(
      .LAYER_COUNT (LAYER_COUNT),
      .LAYER_IDX   (LAYER_COUNT - 1 - s)
    ) u_stage (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .setting_i    (settings_q[LAYER_COUNT-1-s]),
      .in_valid_i   (link_valid[s]),
      .in_ready_o   (link_ready[s]),
      .in_pix_i     (link_pix[s]),
      .in_layers_i  (link_layers[s]),
      .out_valid_o  (link_valid[s+1]),
      .out_ready_i  (link_ready[s+1]),
      .out_pix_o    (link_pix[s+1]),
      .out_layers_o (link_layers[s+1])
    );
  end

  assign link_ready[LAYER_COUNT] = m_axis_tready_i;
  assign m_axis_tvalid_o         = link_valid[LAYER_COUNT];
  assign m_axis_tdata_o          = link_pix[LAYER_COUNT];

  // input backpressure only comes from a pipeline that is full up to a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled while the output is not blocked");

  // nothing leaves the pipeline in the cycle right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid straight after reset");

  // a free output register keeps the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o || m_axis_tready_i) |-> s_axis_tready_o)
    else $error("input blocked with the output draining");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import lbc_pkg::*;

  localparam int unsigned LAYER_COUNT = 5;
  localparam int unsigned IDX_W       = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int unsigned FULL_PCT    = 100;
  localparam int unsigned LATENCY     = 2 * LAYER_COUNT;
  localparam int unsigned ITEMS_PER_BANK = 50;

  typedef logic [LAYER_COUNT-1:0][PIX_W-1:0] stack_t;
  typedef setting_t [LAYER_COUNT-1:0] bank_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [IDX_W-1:0]                 cfg_idx = '0;
  logic [SETTING_W-1:0]             cfg_wdata = '0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [(LAYER_COUNT+1)*PIX_W-1:0] s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [PIX_W-1:0]                 m_tdata;

  bank_t layer_cfg = bank_t'({LAYER_COUNT{SETTING_RESET}});
  pix_t  pending_blends[$];
  int    err_count = 0;
  int    src_idle_pct = 0;
  int    sink_idle_pct = 0;

  layer_blend_compositor #(
    .LAYER_COUNT(LAYER_COUNT)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic chan_t mix_channel(input chan_t a, input chan_t c,
                                        input logic [MODE_W-1:0] mode,
                                        input int unsigned o);
    int unsigned av;
    int unsigned cv;
    int unsigned dim;
    int unsigned scaled;
    av     = a;
    cv     = c;
    dim    = (av < cv) ? av : cv;
    scaled = cv * o / FULL_PCT;
    case (mode)
      MODE_NORMAL:     return chan_t'((av * (FULL_PCT - o) + cv * o) / FULL_PCT);
      MODE_DARKEN:     return chan_t'((av * (FULL_PCT - o) + dim * o) / FULL_PCT);
      MODE_LIGHTEN:    return chan_t'((av > scaled) ? av : scaled);
      MODE_DIFFERENCE: return chan_t'((av > scaled) ? av - scaled : scaled - av);
      MODE_NEGATE:     return chan_t'(av ^ scaled);
      default:         return a;
    endcase
  endfunction

  // top of the stack last: layer LAYER_COUNT-1 first, layer 0 on top
  function automatic pix_t composite_pixel(input pix_t base, input stack_t layers);
    pix_t        acc;
    int unsigned o;
    acc = base;
    for (int k = LAYER_COUNT - 1; k >= 0; k--) begin
      if (layer_cfg[k].enable) begin
        o = (layer_cfg[k].opacity > FULL_PCT) ? FULL_PCT : layer_cfg[k].opacity;
        for (int ch = 0; ch < CH_N; ch++) begin
          acc[ch*CH_W +: CH_W] = mix_channel(acc[ch*CH_W +: CH_W],
                                             layers[k][ch*CH_W +: CH_W],
                                             layer_cfg[k].mode, o);
        end
      end
    end
    return acc;
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    p = pix_t'($urandom);
    if ($urandom_range(3) == 0) begin
      for (int ch = 0; ch < CH_N; ch++) begin
        case ($urandom_range(2))
          0:       p[ch*CH_W +: CH_W] = '0;
          1:       p[ch*CH_W +: CH_W] = '1;
          default: ;
        endcase
      end
    end
    return p;
  endfunction

  // occasionally repeat the base so ties in min/max get hit
  function automatic stack_t rand_stack(input pix_t base);
    stack_t s;
    for (int k = 0; k < LAYER_COUNT; k++) begin
      s[k] = ($urandom_range(7) == 0) ? base : rand_pixel();
    end
    return s;
  endfunction

  function automatic setting_t rand_setting();
    setting_t s;
    s = setting_t'($urandom);
    case ($urandom_range(4))
      0:       s.opacity = '0;
      1:       s.opacity = OPA_FULL;
      2:       s.opacity = OPA_W'($urandom_range(127, FULL_PCT + 1));
      default: s.opacity = OPA_W'($urandom_range(FULL_PCT));
    endcase
    if ($urandom_range(4) == 0)
      s.mode = MODE_W'($urandom_range(7, 5));
    else
      s.mode = MODE_W'($urandom_range(4));
    s.enable = ($urandom_range(4) != 0);
    return s;
  endfunction

  task automatic report_mismatch(input string what, input pix_t want, input pix_t got);
    $display("%0t ns: %s: expected %06h, got %06h", $realtime, what, want, got);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_blends.size() == 0) begin
        report_mismatch("blended_pixel with no item pending", '0, m_tdata);
      end else begin
        if (m_tdata !== pending_blends[0])
          report_mismatch("blended_pixel", pending_blends[0], m_tdata);
        void'(pending_blends.pop_front());
      end
    end
  end

  // leave tvalid high on return so back-to-back items need no extra edge
  task automatic send_pixel(input pix_t base, input stack_t layers);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {layers, base};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    pending_blends = {pending_blends, composite_pixel(base, layers)};
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // out-of-range indexes must leave every layer untouched
  task automatic program_layers(input bank_t bank, input bit poke_unused);
    for (int k = 0; k < LAYER_COUNT; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= IDX_W'(k);
      cfg_wdata <= bank[k];
      @(posedge clk_i);
    end
    layer_cfg = bank;
    if (poke_unused) begin
      for (int k = LAYER_COUNT; k < (1 << IDX_W); k++) begin
        cfg_we    <= 1'b1;
        cfg_idx   <= IDX_W'(k);
        cfg_wdata <= SETTING_W'($urandom);
        @(posedge clk_i);
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_state();
    pix_t base;
    for (int i = 0; i < 3; i++) begin
      base = rand_pixel();
      send_pixel(base, rand_stack(base));
    end
  endtask

  task automatic test_unused_index();
    pix_t base;
    wait_idle();
    program_layers(bank_t'({LAYER_COUNT{SETTING_RESET}}), 1'b1);
    for (int i = 0; i < 2; i++) begin
      base = rand_pixel();
      send_pixel(base, rand_stack(base));
    end
  endtask

  task automatic test_each_mode();
    bank_t  bank;
    stack_t layers;
    pix_t   base;
    for (int md = 0; md < (1 << MODE_W); md++) begin
      bank = '0;
      bank[LAYER_COUNT-1].enable = 1'b1;
      bank[LAYER_COUNT-1].mode   = MODE_W'(md);
      case (md % 4)
        0:       bank[LAYER_COUNT-1].opacity = OPA_FULL;
        1:       bank[LAYER_COUNT-1].opacity = '1;
        2:       bank[LAYER_COUNT-1].opacity = '0;
        default: bank[LAYER_COUNT-1].opacity = OPA_W'($urandom_range(99, 1));
      endcase
      wait_idle();
      program_layers(bank, 1'b0);
      layers = rand_stack(24'h000000);
      layers[LAYER_COUNT-1] = {8'hFF, 8'h00, 8'hC3};
      send_pixel({8'h00, 8'hFF, 8'h5A}, layers);
      base = rand_pixel();
      send_pixel(base, rand_stack(base));
    end
  endtask

  task automatic test_register_extremes();
    pix_t base;
    wait_idle();
    program_layers('0, 1'b0);
    for (int i = 0; i < 2; i++) begin
      base = rand_pixel();
      send_pixel(base, rand_stack(base));
    end
    wait_idle();
    program_layers('1, 1'b0);
    for (int i = 0; i < 2; i++) begin
      base = rand_pixel();
      send_pixel(base, rand_stack(base));
    end
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
    bank_t bank;
    pix_t  base;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % ITEMS_PER_BANK == 0) begin
        wait_idle();
        for (int k = 0; k < LAYER_COUNT; k++) bank[k] = rand_setting();
        program_layers(bank, $urandom_range(3) == 0);
      end
      base = rand_pixel();
      send_pixel(base, rand_stack(base));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_unused_index();
    test_each_mode();
    test_register_extremes();
    test_random_traffic(11, 74, 150);
    test_random_traffic(74, 11, 150);
    test_random_traffic(0, 0, 150);

    wait_idle();
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
